/* hdl/mep_pkg.sv */
// Shared types, constants and fixed-point helpers for the escape-time pixel core.
package mep_pkg;

    localparam int MAX_COLUMNS   = 4096;
    localparam int MAX_ROWS      = 4096;
    localparam int FRACTION_BITS = 28;

    localparam int COORD_W = 32;
    localparam int STEP_W  = 31;
    localparam int IDX_W   = 12;
    localparam int ITER_W  = 16;
    localparam int GRAY_W  = 8;
    localparam int PROD_W  = 2 * COORD_W;
    localparam int CPROD_W = STEP_W + IDX_W;
    localparam int SUM_W   = 48;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_ADDR_W-1:0] CFG_X_MIN  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_Y_MIN  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_STEP_X = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_STEP_Y = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_LIMIT  = 3'd4;

    localparam logic signed [COORD_W-1:0] RST_X_MIN  = -32'sd536870912;
    localparam logic signed [COORD_W-1:0] RST_Y_MIN  = -32'sd402653184;
    localparam logic [STEP_W-1:0]         RST_STEP_X = 31'd786432;
    localparam logic [STEP_W-1:0]         RST_STEP_Y = 31'd786432;
    localparam logic [ITER_W-1:0]         RST_LIMIT  = 16'd255;

    // escape radius squared (4.0) in fixed point
    localparam logic [COORD_W:0] ESCAPE_MAG = (COORD_W+1)'(4) << FRACTION_BITS;

    localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    typedef struct packed {
        logic load_in;
        logic c_mul;
        logic c_sum;
        logic it_mul;
        logic it_step;
        logic div_start;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic in_radius;
        logic at_limit;
        logic div_done;
        logic out_free;
    } t_dp_sts;

    // saturate a wide signed sum to the coordinate range
    function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [SUM_W-1:0] v);
        logic hi_same;
        hi_same = (&v[SUM_W-1:COORD_W-1]) | ~(|v[SUM_W-1:COORD_W-1]);
        if (hi_same) begin
            return v[COORD_W-1:0];
        end else if (v[SUM_W-1]) begin
            return COORD_MIN;
        end else begin
            return COORD_MAX;
        end
    endfunction

    // rescale a square (never negative) and clip at the top of the range
    function automatic logic signed [COORD_W-1:0] sat_square(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] s;
        s = p >>> FRACTION_BITS;
        if (|s[PROD_W-1:COORD_W-1]) begin
            return COORD_MAX;
        end else begin
            return s[COORD_W-1:0];
        end
    endfunction

endpackage

/* hdl/mandelbrot_escape_pixel_core.sv */
// Each iteration is a multiply step (three parallel 32x32 multiplies), then the update.
// One item at a time: the next item is accepted once this one's result is in the output register.
// The gray level comes from a restoring divider after the loop.
// Synchronous active-low reset clears control and loads the default registers.
module mandelbrot_escape_pixel_core
    import mep_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [23:0]           s_axis_tdata,  // column[11:0], row[23:12]
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [23:0]           m_axis_tdata,  // iterations[15:0], gray_level[23:16]
    output logic                  m_axis_tuser,  // reached_limit[0]
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic signed [COORD_W-1:0] r_x_min, r_y_min;
    logic [STEP_W-1:0]         r_step_x, r_step_y;
    logic [ITER_W-1:0]         r_limit;

    logic                      r_out_valid;
    logic [ITER_W-1:0]         r_out_iter;
    logic [GRAY_W-1:0]         r_out_gray;
    logic                      r_out_lim;

    t_dp_cmd                   cmd;
    t_dp_sts                   sts;
    logic [ITER_W-1:0]         count;
    logic                      in_radius, at_limit, div_done;
    logic [GRAY_W-1:0]         quot;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_min  <= RST_X_MIN;
            r_y_min  <= RST_Y_MIN;
            r_step_x <= RST_STEP_X;
            r_step_y <= RST_STEP_Y;
            r_limit  <= RST_LIMIT;
        end else if (i_cfg_valid) begin
            case (i_cfg_addr)
                CFG_X_MIN:  r_x_min  <= i_cfg_data[COORD_W-1:0];
                CFG_Y_MIN:  r_y_min  <= i_cfg_data[COORD_W-1:0];
                CFG_STEP_X: r_step_x <= i_cfg_data[STEP_W-1:0];
                CFG_STEP_Y: r_step_y <= i_cfg_data[STEP_W-1:0];
                CFG_LIMIT:  r_limit  <= i_cfg_data[ITER_W-1:0];
                default: ;
            endcase
        end
    end

    assign sts.in_radius = in_radius;
    assign sts.at_limit  = at_limit;
    assign sts.div_done  = div_done;
    assign sts.out_free  = !r_out_valid || m_axis_tready;

    mep_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    mep_dp u_dp (
        .i_clk      (i_clk),
        .i_cmd      (cmd),
        .i_column   (s_axis_tdata[11:0]),
        .i_row      (s_axis_tdata[23:12]),
        .i_x_min    (r_x_min),
        .i_y_min    (r_y_min),
        .i_step_x   (r_step_x),
        .i_step_y   (r_step_y),
        .i_limit    (r_limit),
        .o_count    (count),
        .o_inside   (in_radius),
        .o_at_limit (at_limit)
    );

    mep_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cmd.div_start),
        .i_count (count),
        .i_limit (r_limit),
        .o_done  (div_done),
        .o_quot  (quot)
    );

    // result register: the next item can start while this one waits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd.load_out) begin
            r_out_iter <= count;
            r_out_gray <= quot;
            r_out_lim  <= in_radius;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_gray, r_out_iter};
    assign m_axis_tuser  = r_out_lim;

endmodule

/* hdl/mep_div.sv */
// Restoring divider for the gray level: iterations*255/limit, one quotient bit per cycle.
module mep_div
    import mep_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [ITER_W-1:0] i_count,
    input  logic [ITER_W-1:0] i_limit,
    output logic              o_done,
    output logic [GRAY_W-1:0] o_quot
);

    localparam int DVD_W = ITER_W + GRAY_W;
    localparam int CNT_W = $clog2(GRAY_W);

    logic              r_busy;
    logic [CNT_W-1:0]  r_cnt;
    logic [ITER_W-1:0] r_rem;
    logic [GRAY_W-1:0] r_low;
    logic [ITER_W-1:0] r_lim;

    logic [DVD_W-1:0]  dividend;
    logic [ITER_W:0]   trial;
    logic              fits;

    // count*255 = count*256 - count; quotient stays below 256 since count <= limit
    assign dividend = {i_count, {GRAY_W{1'b0}}} - DVD_W'(i_count);
    assign trial    = {r_rem, r_low[GRAY_W-1]};
    assign fits     = trial >= {1'b0, r_lim};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(GRAY_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= dividend[DVD_W-1:GRAY_W];
            r_low <= dividend[GRAY_W-1:0];
            r_lim <= i_limit;
        end else if (r_busy) begin
            r_rem <= fits ? ITER_W'(trial - {1'b0, r_lim}) : trial[ITER_W-1:0];
            r_low <= {r_low[GRAY_W-2:0], fits};
        end
    end

    assign o_done = r_busy && (r_cnt == CNT_W'(GRAY_W - 1));
    // a zero limit gives a zero gray level
    assign o_quot = (r_lim == '0) ? '0 : r_low;

endmodule

/* hdl/mep_dp.sv */
// Datapath: point coordinates, z registers, two coordinate and three iteration multipliers, and the update stage.
module mep_dp
    import mep_pkg::*;
(
    input  logic                      i_clk,
    input  t_dp_cmd                   i_cmd,
    input  logic [IDX_W-1:0]          i_column,
    input  logic [IDX_W-1:0]          i_row,
    input  logic signed [COORD_W-1:0] i_x_min,
    input  logic signed [COORD_W-1:0] i_y_min,
    input  logic [STEP_W-1:0]         i_step_x,
    input  logic [STEP_W-1:0]         i_step_y,
    input  logic [ITER_W-1:0]         i_limit,
    output logic [ITER_W-1:0]         o_count,
    output logic                      o_inside,
    output logic                      o_at_limit
);

    localparam logic [IDX_W:0] COL_LAST = (IDX_W+1)'(MAX_COLUMNS - 1);
    localparam logic [IDX_W:0] ROW_LAST = (IDX_W+1)'(MAX_ROWS - 1);

    logic [IDX_W-1:0]          r_col, r_row;
    logic [CPROD_W-1:0]        r_pcx, r_pcy;
    logic signed [COORD_W-1:0] r_cx, r_cy, r_x, r_y;
    logic signed [PROD_W-1:0]  r_pxx, r_pyy, r_pxy;
    logic [ITER_W-1:0]         r_n;

    logic [IDX_W-1:0]          col_c, row_c;
    logic signed [SUM_W-1:0]   cx_sum, cy_sum, nx_sum, ny_sum;
    logic signed [COORD_W-1:0] x2, y2, cx, cy;
    logic signed [PROD_W-1:0]  xy_sc;
    logic [COORD_W:0]          mag;

    assign col_c = ({1'b0, i_column} > COL_LAST) ? COL_LAST[IDX_W-1:0] : i_column;
    assign row_c = ({1'b0, i_row} > ROW_LAST) ? ROW_LAST[IDX_W-1:0] : i_row;

    assign cx_sum = SUM_W'(i_x_min) + $signed(SUM_W'(r_pcx));
    assign cy_sum = SUM_W'(i_y_min) + $signed(SUM_W'(r_pcy));
    assign cx     = sat_coord(cx_sum);
    assign cy     = sat_coord(cy_sum);

    assign x2  = sat_square(r_pxx);
    assign y2  = sat_square(r_pyy);
    assign mag = {1'b0, x2} + {1'b0, y2};

    // 2xy is the product rescaled by one bit less
    assign xy_sc  = r_pxy >>> (FRACTION_BITS - 1);
    assign ny_sum = xy_sc[SUM_W-1:0] + SUM_W'(r_cy);
    assign nx_sum = SUM_W'(x2) - SUM_W'(y2) + SUM_W'(r_cx);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_col <= col_c;
            r_row <= row_c;
        end
        if (i_cmd.c_mul) begin
            r_pcx <= CPROD_W'(i_step_x) * CPROD_W'(r_col);
            r_pcy <= CPROD_W'(i_step_y) * CPROD_W'(r_row);
        end
        if (i_cmd.c_sum) begin
            r_cx <= cx;
            r_cy <= cy;
            r_x  <= cx;
            r_y  <= cy;
            r_n  <= '0;
        end
        if (i_cmd.it_mul) begin
            r_pxx <= PROD_W'(r_x) * PROD_W'(r_x);
            r_pyy <= PROD_W'(r_y) * PROD_W'(r_y);
            r_pxy <= PROD_W'(r_x) * PROD_W'(r_y);
        end
        if (i_cmd.it_step) begin
            r_x <= sat_coord(nx_sum);
            r_y <= sat_coord(ny_sum);
            r_n <= r_n + 1'b1;
        end
    end

    assign o_count    = r_n;
    assign o_inside   = mag < ESCAPE_MAG;
    assign o_at_limit = !(r_n < i_limit);

endmodule

/* hdl/mep_ctrl.sv */
// Sequencer: coordinate setup, multiply/update iteration loop, divide, hand-off.
module mep_ctrl
    import mep_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMUL,
        S_CSUM,
        S_MUL,
        S_UPD,
        S_DIV,
        S_HOLD
    } t_state;

    t_state r_state, n_state;
    logic   go_on;

    assign go_on = i_sts.in_radius && !i_sts.at_limit;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.load_in = i_in_valid;
                if (i_in_valid) n_state = S_CMUL;
            end
            S_CMUL: begin
                o_cmd.c_mul = 1'b1;
                n_state     = S_CSUM;
            end
            S_CSUM: begin
                o_cmd.c_sum = 1'b1;
                n_state     = S_MUL;
            end
            S_MUL: begin
                o_cmd.it_mul = 1'b1;
                n_state      = S_UPD;
            end
            S_UPD: begin
                if (go_on) begin
                    o_cmd.it_step = 1'b1;
                    n_state       = S_MUL;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end
            end
            S_DIV: begin
                if (i_sts.div_done) n_state = S_HOLD;
            end
            S_HOLD: begin
                o_cmd.load_out = i_sts.out_free;
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

/* hdl/mep_checker.sv */
// Port-level checker for the escape-time pixel core, bound to the top level.
module mep_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    logic [1:0] r_pend;
    logic       in_acc, out_acc;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;

    // items accepted whose result is not yet taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else if (in_acc && !out_acc) begin
            r_pend <= r_pend + 1'b1;
        end else if (out_acc && !in_acc) begin
            r_pend <= r_pend - 1'b1;
        end
    end

    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_pend != 2'd0))
        else $error("result shown with no item outstanding");

    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend != 2'd3)
        else $error("more than two items in flight");

    a_inside_full_gray: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser && (m_axis_tdata[15:0] != 16'd0))
            |-> (m_axis_tdata[23:16] == 8'd255))
        else $error("limit reached but gray level not full scale");

    a_zero_gray: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tdata[15:0] == 16'd0)) |-> (m_axis_tdata[23:16] == 8'd0))
        else $error("zero iterations with nonzero gray level");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready)
            |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind mandelbrot_escape_pixel_core mep_checker u_mep_checker (.*);
